/* src/aes128_pkg.sv */
// Shared constants and byte functions for the AES-128 encryption pipeline.
// No dependencies; used by aes128_round_cell and aes128_block_encrypt_top.
`default_nettype none
package aes128_pkg;

    localparam int unsigned BlockW = 128;
    localparam int unsigned HalfW  = 64;
    localparam int unsigned Rounds = 10;

    localparam logic [0:0] CfgKeyHigh = 1'b0;
    localparam logic [0:0] CfgKeyLow  = 1'b1;

    localparam logic [7:0] RconFirst = 8'h01;
    localparam logic [7:0] RconLast  = 8'h36;

    typedef logic [BlockW-1:0] t_block;
    typedef logic [7:0]        t_byte;

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic t_byte xtime(input t_byte b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_byte get_byte(input t_block s, input int unsigned i);
        return s[BlockW-1-8*i -: 8];
    endfunction

endpackage
`default_nettype wire

/* src/aes128_round_cell.sv */
// One AES round cell: a round of the cipher plus one step of the key schedule.
// Depends on aes128_pkg. The round constant travels with the data and marks the last round.
`default_nettype none
module aes128_round_cell
    import aes128_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_block i_state,
    input  wire t_block i_key,
    input  wire t_byte  i_rcon,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_block      o_state,
    output t_block      o_key,
    output t_byte       o_rcon
);

    logic   r_valid;
    t_block r_state, r_key;
    t_byte  r_rcon;
    t_block n_state, n_key;
    t_byte  n_rcon;

    t_block sub_sh;
    t_block mixed;
    logic   last;

    always_comb begin
        logic [31:0] w0, w1, w2, w3, t;
        t_byte       a0, a1, a2, a3, all;
        w0 = i_key[127:96];
        w1 = i_key[95:64];
        w2 = i_key[63:32];
        w3 = i_key[31:0];
        // RotWord then SubWord on the last word.
        t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        t  = t ^ {i_rcon, 24'h0};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        n_key  = {w0, w1, w2, w3};
        n_rcon = xtime(i_rcon);
        last   = (i_rcon == RconLast);

        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sub_sh[BlockW-1-8*(4*c+r) -: 8] = SBOX[get_byte(i_state, 4*((c+r)%4)+r)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(sub_sh, 4*c);
            a1  = get_byte(sub_sh, 4*c+1);
            a2  = get_byte(sub_sh, 4*c+2);
            a3  = get_byte(sub_sh, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            mixed[BlockW-1-32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1),
                                          a1 ^ all ^ xtime(a1 ^ a2),
                                          a2 ^ all ^ xtime(a2 ^ a3),
                                          a3 ^ all ^ xtime(a3 ^ a0)};
        end
        n_state = (last ? sub_sh : mixed) ^ n_key;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_state <= n_state;
            r_key   <= n_key;
            r_rcon  <= n_rcon;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;
    assign o_rcon  = r_rcon;

endmodule
`default_nettype wire

/* src/aes128_block_encrypt_top.sv */
// AES-128 encryption top level: key registers, entry stage and a chain of ten round cells.
// Depends on aes128_pkg and aes128_round_cell.
//
// Usage: write the key through i_cfg_we / i_cfg_index / i_cfg_data (index 0 is the
// upper 64 key bits, index 1 the lower; the index is one bit wide). Plaintext
// requests arrive on i_valid / o_stall with i_plaintext_high/low; ciphertext
// requests leave on o_valid / i_stall with o_ciphertext_high/low.
// Each block passes an entry stage (initial key addition) and ten round cells,
// each a register stage. The round key moves along the chain with its block,
// so one block is accepted every cycle while o_stall is low.
// Each stage advances whenever it is empty or the stage after it advances; a
// stall at the output fills the chain and only then raises o_stall, and bubbles
// are squeezed out while stalled.
// Reset (synchronous, active low) empties the chain and clears the key to zero.
`default_nettype none
module aes128_block_encrypt_top
    import aes128_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [HalfW-1:0]  i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [HalfW-1:0]  i_plaintext_high,
    input  wire logic [HalfW-1:0]  i_plaintext_low,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [HalfW-1:0]       o_ciphertext_high,
    output logic [HalfW-1:0]       o_ciphertext_low
);

    logic [HalfW-1:0] r_key_high, r_key_low;
    logic   r_valid;
    t_block r_state, r_key;

    logic   vld   [Rounds+1];
    logic   rdy   [Rounds+1];
    t_block st    [Rounds+1];
    t_block ky    [Rounds+1];
    t_byte  rc    [Rounds+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgKeyHigh: r_key_high <= i_cfg_data;
                CfgKeyLow:  r_key_low  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Entry stage: initial round-key addition.
    logic in_ready;
    assign in_ready = !r_valid || rdy[0];
    assign o_stall  = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_state <= {i_plaintext_high, i_plaintext_low} ^ {r_key_high, r_key_low};
            r_key   <= {r_key_high, r_key_low};
        end
    end

    assign vld[0] = r_valid;
    assign st[0]  = r_state;
    assign ky[0]  = r_key;
    assign rc[0]  = RconFirst;

    for (genvar k = 0; k < Rounds; k++) begin : g_round
        aes128_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[k]),
            .o_ready (rdy[k]),
            .i_state (st[k]),
            .i_key   (ky[k]),
            .i_rcon  (rc[k]),
            .o_valid (vld[k+1]),
            .i_ready (rdy[k+1]),
            .o_state (st[k+1]),
            .o_key   (ky[k+1]),
            .o_rcon  (rc[k+1])
        );
    end

    assign rdy[Rounds]       = !i_stall;
    assign o_valid           = vld[Rounds];
    assign o_ciphertext_high = st[Rounds][BlockW-1:HalfW];
    assign o_ciphertext_low  = st[Rounds][HalfW-1:0];

endmodule
`default_nettype wire
